// ===== hdl/ida_pkg.sv =====
// ida_pkg: shared constants for the ID allocator with free stack
// request kinds, status codes and default sizes
// no dependencies

package ida_pkg;

	// default sizes
	localparam int ID_WIDTH_DEF   = 10;
	localparam int FREE_DEPTH_DEF = 1024;

	// request kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	// response status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [1:0] ST_FREE_NONE  = 2'd2;
	localparam logic [1:0] ST_STACK_FULL = 2'd3;

endpackage

// ===== hdl/ida_if.sv =====
// ida_if: request and response channel interfaces of the ID allocator
// valid/ready handshake, a transfer happens when both are high
// depends on ida_pkg for the default ID width

interface ida_req_if #(
	parameter int ID_WIDTH = ida_pkg::ID_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic [ID_WIDTH-1:0] id;

	modport source (output valid, output kind, output id, input ready);
	modport sink   (input valid, input kind, input id, output ready);
endinterface

interface ida_rsp_if #(
	parameter int ID_WIDTH = ida_pkg::ID_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic [ID_WIDTH-1:0] result_id;
	logic                is_allocated;
	logic [1:0]          status;

	modport source (output valid, output result_id, output is_allocated, output status,
		input ready);
	modport sink   (input valid, input result_id, input is_allocated, input status,
		output ready);
endinterface

// ===== hdl/id_allocator_free_stack.sv =====
// id_allocator_free_stack: hands out IDs from a watermark and a LIFO of freed IDs
// depends on ida_pkg and the ida_req_if / ida_rsp_if channel interfaces

// One request at a time; req.ready is high only while the sequencer is idle, and
// the response register lets a finished result wait while the next request is taken.
// From the request transfer, allocate from the watermark, free and rejected requests
// go straight to S_FINISH; allocate from the stack passes through S_POP for the
// registered read of the free-stack memory; a query of an ID below the watermark
// with a non-empty stack passes through S_SCAN, where a single comparator walks the
// stack memory one entry per cycle through its one read port, stopping at the first
// match. A response that is not taken holds the sequencer in its last state. The
// stack memory needs no clearing pass.

module id_allocator_free_stack #(
	parameter int ID_WIDTH   = ida_pkg::ID_WIDTH_DEF,
	parameter int FREE_DEPTH = ida_pkg::FREE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ida_req_if.sink      req,
	ida_rsp_if.source    rsp
);

	localparam int AW = $clog2(FREE_DEPTH);
	localparam int CW = $clog2(FREE_DEPTH + 1);
	localparam logic [CW-1:0]       DEPTH_C = CW'(FREE_DEPTH);
	localparam logic [ID_WIDTH-1:0] NO_ID   = {ID_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [ID_WIDTH-1:0] watermark_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [CW-1:0]       idx_q;
	logic                rd_vld_s1;
	logic                last_s1;
	logic [ID_WIDTH-1:0] rd_data_s1;
	logic [ID_WIDTH-1:0] res_id_q;
	logic                res_alloc_q;
	logic [1:0]          res_status_q;
	logic                out_valid_q;
	logic [ID_WIDTH-1:0] out_id_q;
	logic                out_alloc_q;
	logic [1:0]          out_status_q;

	logic [ID_WIDTH-1:0] mem [FREE_DEPTH];

	logic                acc;
	logic                mem_we;
	logic                mem_re;
	logic                pop_go;
	logic                scan_issue;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [CW-1:0]       cnt_m1;
	logic                hit;
	logic                out_free;

	// handshake and memory port control
	always_comb begin
		acc        = req.valid && (state_q == S_IDLE);
		cnt_m1     = count_q - CW'(1);
		mem_we     = acc && (req.kind == ida_pkg::KIND_FREE) && (req.id != NO_ID)
			&& (count_q != DEPTH_C);
		wr_addr    = count_q[AW-1:0];
		pop_go     = acc && (req.kind == ida_pkg::KIND_ALLOC) && (count_q != '0);
		scan_issue = (state_q == S_SCAN) && (idx_q < count_q);
		mem_re     = pop_go || scan_issue;
		rd_addr    = pop_go ? cnt_m1[AW-1:0] : idx_q[AW-1:0];
		hit        = (rd_data_s1 == id_q);
		out_free   = !out_valid_q || rsp.ready;
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.result_id    = out_id_q;
	assign rsp.is_allocated = out_alloc_q;
	assign rsp.status       = out_status_q;

	// free-stack memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= req.id;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// sequencer with response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			watermark_q  <= '0;
			id_q         <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			last_s1      <= 1'b0;
			res_id_q     <= '0;
			res_alloc_q  <= 1'b0;
			res_status_q <= ida_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_id_q     <= '0;
			out_alloc_q  <= 1'b0;
			out_status_q <= ida_pkg::ST_OK;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						id_q         <= req.id;
						res_id_q     <= '0;
						res_alloc_q  <= 1'b0;
						res_status_q <= ida_pkg::ST_OK;
						state_q      <= S_FINISH;
						case (req.kind)
							ida_pkg::KIND_ALLOC: begin
								if (count_q != '0) begin
									count_q <= cnt_m1;
									state_q <= S_POP;
								end else if (watermark_q == NO_ID) begin
									res_id_q     <= NO_ID;
									res_status_q <= ida_pkg::ST_EXHAUSTED;
								end else begin
									res_id_q    <= watermark_q;
									watermark_q <= watermark_q + ID_WIDTH'(1);
								end
							end
							ida_pkg::KIND_QUERY: begin
								if (req.id == NO_ID || req.id >= watermark_q
									|| count_q == '0) begin
									res_alloc_q <= (req.id != NO_ID) && (req.id < watermark_q);
								end else begin
									idx_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							ida_pkg::KIND_FREE: begin
								if (req.id == NO_ID) begin
									res_status_q <= ida_pkg::ST_FREE_NONE;
								end else if (count_q == DEPTH_C) begin
									res_status_q <= ida_pkg::ST_STACK_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					// registered read of the top entry is back
					res_id_q <= rd_data_s1;
					state_q  <= S_FINISH;
				end
				S_SCAN: begin
					// walk the stack, compare one entry per cycle
					if (scan_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					rd_vld_s1 <= scan_issue;
					last_s1   <= (idx_q == cnt_m1);
					if (rd_vld_s1 && (hit || last_s1)) begin
						res_alloc_q <= !hit;
						rd_vld_s1   <= 1'b0;
						state_q     <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hand result to the response register once it is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_id_q     <= res_id_q;
						out_alloc_q  <= res_alloc_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// stack fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("free count above stack depth");

	// the stack does not move while it is being scanned
	a_scan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> (state_q != S_SCAN) || $stable(count_q))
		else $error("free count changed during scan");

	// watermark only steps up by one
	a_wm_step: assert property (@(posedge clk) disable iff (!arst_n)
		(watermark_q != $past(watermark_q)) |->
		(watermark_q == $past(watermark_q) + ID_WIDTH'(1)))
		else $error("watermark moved by other than one");

	// exhaustion always reports the no-ID value
	a_exhausted_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ida_pkg::ST_EXHAUSTED) |-> (out_id_q == NO_ID))
		else $error("exhausted response without no-ID");

	// a successful allocate never grants the no-ID value
	a_no_grant_none: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (rd_data_s1 != NO_ID))
		else $error("no-ID popped from free stack");

endmodule
